@@ hdl/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded probe source table package
// Shared types and fixed constants for the source table and its slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

   // Width of the key and of the timestamp.
   localparam int KEY_W  = 32;
   localparam int TIME_W = 64;

   // Hash mix constants.
   localparam logic [KEY_W-1:0] MIX_MULT  = 32'h045d_9f3b;
   localparam int               MIX_SHIFT = 16;

   // The reported slot index is the slot number masked to ten bits.
   typedef logic [9:0] slot_index_type;

   // Lookup outcome codes.
   typedef enum logic [1:0] {
      OUTCOME_HIT   = 2'd0,
      OUTCOME_CLAIM = 2'd1,
      OUTCOME_EVICT = 2'd2
   } outcome_type;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_MIX_A  = 8'b0000_0100,
      ST_MIX_B  = 8'b0000_1000,
      ST_MIX_C  = 8'b0001_0000,
      ST_MODULO = 8'b0010_0000,
      ST_ISSUE  = 8'b0100_0000,
      ST_PROBE  = 8'b1000_0000
   } state_type;

   // Write enables into the slot store.
   typedef struct packed {
      logic owner_we;
      logic birth_we;
   } store_wr_type;

endpackage

`default_nettype wire

@@ hdl/bps_slot_store.sv @@
// ----------------------------------------------------------------------------
// Slot store
// Owner and creation time memories: one shared write port, one registered
// read port addressed by the sequencer every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_slot_store #(
   parameter int TABLE_SLOTS = 1024
) (
   input  wire logic                          clock,
   input  wire bps_pkg::store_wr_type         wr_ctl,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
   input  wire logic [bps_pkg::KEY_W-1:0]     wr_owner,
   input  wire logic [bps_pkg::TIME_W-1:0]    wr_birth,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
   output logic      [bps_pkg::KEY_W-1:0]     rd_owner,
   output logic      [bps_pkg::TIME_W-1:0]    rd_birth
);

   logic [bps_pkg::KEY_W-1:0]  owner_mem [TABLE_SLOTS];
   logic [bps_pkg::TIME_W-1:0] birth_mem [TABLE_SLOTS];
   logic [bps_pkg::KEY_W-1:0]  owner_rd_ff;
   logic [bps_pkg::TIME_W-1:0] birth_rd_ff;

   // Owner memory: write, then registered read.
   always_ff @(posedge clock) begin
      if (wr_ctl.owner_we) begin
         owner_mem[wr_addr] <= wr_owner;
      end
      owner_rd_ff <= owner_mem[rd_addr];
   end

   // Creation time memory: written only when an owner is stamped.
   always_ff @(posedge clock) begin
      if (wr_ctl.birth_we) begin
         birth_mem[wr_addr] <= wr_birth;
      end
      birth_rd_ff <= birth_mem[rd_addr];
   end

   assign rd_owner = owner_rd_ff;
   assign rd_birth = birth_rd_ff;

endmodule

`default_nettype wire

@@ hdl/bounded_probe_source_table.sv @@
// Each lookup hashes the key, reduces the probe base modulo TABLE_SLOTS and probes 1 to
// PROBE_DEPTH slots; only a TABLE_SLOTS that is not a power of two needs the modulo steps
// (reciprocal multiply, then one subtract). busy stays high from the accepting edge until
// the result strobe rises, so no new item is taken before the last one is through. One
// multiplier serves every product. Reset starts a clearing pass over every slot of the
// owner store with busy high; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
// Bounded probe source table
// Hashes a source address, probes a bounded window of slots and reports the
// slot the source now owns: hit, claim of an empty slot, or eviction of the
// oldest entry in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_probe_source_table #(
   parameter int TABLE_SLOTS = 1024,
   parameter int PROBE_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bps_pkg::KEY_W-1:0]     req_source_ip,
   input  wire logic [bps_pkg::TIME_W-1:0]    req_now_time,
   output logic                               rsp_strobe,
   output logic      [9:0]                    rsp_slot_index,
   output logic      [1:0]                    rsp_outcome
);

   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int PROBE_W = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
   localparam bit SlotsPow2 = ((1 << SLOT_W) == TABLE_SLOTS);
   localparam logic [SLOT_W-1:0]  LastSlot  = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [PROBE_W-1:0] LastProbe = PROBE_W'(PROBE_DEPTH - 1);
   // Reciprocal of the table size, scaled so that it fits one 32-bit operand.
   localparam int                 RecipShift = 31 + SLOT_W;
   localparam logic [31:0]        Recip      = 32'((64'd1 << RecipShift) / 64'(TABLE_SLOTS));
   localparam logic [31:0]        SlotsWord  = 32'(TABLE_SLOTS);

   // Sequencer and item registers.
   bps_pkg::state_type               state_ff, state_in;
   logic [bps_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [bps_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [bps_pkg::KEY_W-1:0]        prod_ff, prod_in;
   logic [bps_pkg::KEY_W-1:0]        addr_ff, addr_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [SLOT_W-1:0]                cmp_slot_ff, cmp_slot_in;
   logic [SLOT_W-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [1:0]                       mod_step_ff, mod_step_in;
   logic [PROBE_W-1:0]               cmp_cnt_ff, cmp_cnt_in;
   logic [SLOT_W-1:0]                victim_ff, victim_in;
   logic [bps_pkg::TIME_W-1:0]       vbirth_ff, vbirth_in;

   // Result registers.
   logic                             rsp_strobe_ff, rsp_strobe_in;
   bps_pkg::slot_index_type          rsp_index_ff, rsp_index_in;
   bps_pkg::outcome_type             rsp_outcome_ff, rsp_outcome_in;

   // Shared multiplier and helpers.
   logic [bps_pkg::KEY_W-1:0]        mul_a;
   logic [bps_pkg::KEY_W-1:0]        mul_b;
   logic [2*bps_pkg::KEY_W-1:0]      mul_res;
   logic [2*bps_pkg::KEY_W-1:0]      quot_full;
   logic [bps_pkg::KEY_W-1:0]        mix_base;
   logic [SLOT_W-1:0]                slot_next;
   logic [bps_pkg::KEY_W-1:0]        mod_rem;
   logic                             take_cur;
   logic [SLOT_W-1:0]                cand_slot;
   logic [bps_pkg::TIME_W-1:0]       cand_birth;

   // Store interface.
   bps_pkg::store_wr_type            wr_ctl;
   logic [SLOT_W-1:0]                wr_addr;
   logic [bps_pkg::KEY_W-1:0]        wr_owner;
   logic [bps_pkg::KEY_W-1:0]        rd_owner;
   logic [bps_pkg::TIME_W-1:0]       rd_birth;

   bps_slot_store #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_store (
      .clock    (clock),
      .wr_ctl   (wr_ctl),
      .wr_addr  (wr_addr),
      .wr_owner (wr_owner),
      .wr_birth (now_ff),
      .rd_addr  (slot_ff),
      .rd_owner (rd_owner),
      .rd_birth (rd_birth)
   );

   // The one multiplier: the hash keeps the low word, the quotient estimate the full product.
   assign mul_res   = mul_a * mul_b;
   assign quot_full = mul_res >> RecipShift;
   assign mix_base  = prod_ff ^ (prod_ff >> bps_pkg::MIX_SHIFT);

   // Next probe slot: a wrap of the 32-bit probe address restarts at slot zero.
   assign slot_next = ((addr_ff == '1) || (slot_ff == LastSlot)) ? '0 : slot_ff + 1'b1;

   // The estimated quotient is at most one short, so one subtract finishes the modulo.
   assign mod_rem = (prod_ff >= SlotsWord) ? prod_ff - SlotsWord : prod_ff;

   // Oldest-entry tracking: the first probe always takes, ties keep the earlier slot.
   assign take_cur   = (cmp_cnt_ff == '0) || (rd_birth < vbirth_ff);
   assign cand_slot  = take_cur ? cmp_slot_ff : victim_ff;
   assign cand_birth = take_cur ? rd_birth : vbirth_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      now_in         = now_ff;
      prod_in        = prod_ff;
      addr_in        = addr_ff;
      slot_in        = slot_ff;
      cmp_slot_in    = cmp_slot_ff;
      clr_cnt_in     = clr_cnt_ff;
      mod_step_in    = mod_step_ff;
      cmp_cnt_in     = cmp_cnt_ff;
      victim_in      = victim_ff;
      vbirth_in      = vbirth_ff;
      rsp_strobe_in  = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_outcome_in = rsp_outcome_ff;
      mul_a          = '0;
      mul_b          = bps_pkg::MIX_MULT;
      wr_ctl         = '0;
      wr_addr        = cmp_slot_ff;
      wr_owner       = key_ff;

      case (state_ff)
         bps_pkg::ST_CLEAR: begin
            wr_ctl.owner_we = 1'b1;
            wr_addr         = clr_cnt_ff;
            wr_owner        = '0;
            if (clr_cnt_ff == LastSlot) begin
               state_in = bps_pkg::ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         bps_pkg::ST_IDLE: begin
            if (start) begin
               key_in   = req_source_ip;
               now_in   = req_now_time;
               state_in = bps_pkg::ST_MIX_A;
            end
         end

         // First xor-shift and multiply.
         bps_pkg::ST_MIX_A: begin
            mul_a    = key_ff ^ (key_ff >> bps_pkg::MIX_SHIFT);
            prod_in  = mul_res[bps_pkg::KEY_W-1:0];
            state_in = bps_pkg::ST_MIX_B;
         end

         // Second xor-shift and multiply on the same unit.
         bps_pkg::ST_MIX_B: begin
            mul_a    = mix_base;
            prod_in  = mul_res[bps_pkg::KEY_W-1:0];
            state_in = bps_pkg::ST_MIX_C;
         end

         // Final xor-shift gives the probe base.
         bps_pkg::ST_MIX_C: begin
            addr_in = mix_base;
            if (SlotsPow2) begin
               slot_in  = mix_base[SLOT_W-1:0];
               state_in = bps_pkg::ST_ISSUE;
            end else begin
               mod_step_in = 2'd0;
               state_in    = bps_pkg::ST_MODULO;
            end
         end

         // Base modulo the table size: quotient estimate, product, difference, fix-up.
         bps_pkg::ST_MODULO: begin
            mod_step_in = mod_step_ff + 1'b1;
            case (mod_step_ff)
               2'd0: begin
                  mul_a   = addr_ff;
                  mul_b   = Recip;
                  prod_in = quot_full[bps_pkg::KEY_W-1:0];
               end
               2'd1: begin
                  mul_a   = prod_ff;
                  mul_b   = SlotsWord;
                  prod_in = mul_res[bps_pkg::KEY_W-1:0];
               end
               2'd2: begin
                  prod_in = addr_ff - prod_ff;
               end
               default: begin
                  slot_in  = mod_rem[SLOT_W-1:0];
                  state_in = bps_pkg::ST_ISSUE;
               end
            endcase
         end

         // First read is in flight; start the walk.
         bps_pkg::ST_ISSUE: begin
            cmp_slot_in = slot_ff;
            slot_in     = slot_next;
            addr_in     = addr_ff + 1'b1;
            cmp_cnt_in  = '0;
            state_in    = bps_pkg::ST_PROBE;
         end

         // Compare one slot per cycle while the next one is read.
         bps_pkg::ST_PROBE: begin
            cmp_slot_in = slot_ff;
            slot_in     = slot_next;
            addr_in     = addr_ff + 1'b1;
            if (rd_owner == key_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_index_in   = bps_pkg::slot_index_type'(cmp_slot_ff);
               rsp_outcome_in = bps_pkg::OUTCOME_HIT;
               state_in       = bps_pkg::ST_IDLE;
            end else if (rd_owner == '0) begin
               wr_ctl.owner_we = 1'b1;
               wr_ctl.birth_we = 1'b1;
               wr_addr         = cmp_slot_ff;
               rsp_strobe_in   = 1'b1;
               rsp_index_in    = bps_pkg::slot_index_type'(cmp_slot_ff);
               rsp_outcome_in  = bps_pkg::OUTCOME_CLAIM;
               state_in        = bps_pkg::ST_IDLE;
            end else begin
               victim_in = cand_slot;
               vbirth_in = cand_birth;
               if (cmp_cnt_ff == LastProbe) begin
                  wr_ctl.owner_we = 1'b1;
                  wr_ctl.birth_we = 1'b1;
                  wr_addr         = cand_slot;
                  rsp_strobe_in   = 1'b1;
                  rsp_index_in    = bps_pkg::slot_index_type'(cand_slot);
                  rsp_outcome_in  = bps_pkg::OUTCOME_EVICT;
                  state_in        = bps_pkg::ST_IDLE;
               end else begin
                  cmp_cnt_in = cmp_cnt_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = bps_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bps_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      now_ff         <= now_in;
      prod_ff        <= prod_in;
      addr_ff        <= addr_in;
      slot_ff        <= slot_in;
      cmp_slot_ff    <= cmp_slot_in;
      mod_step_ff    <= mod_step_in;
      cmp_cnt_ff     <= cmp_cnt_in;
      victim_ff      <= victim_in;
      vbirth_ff      <= vbirth_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign busy           = (state_ff != bps_pkg::ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot_index = rsp_index_ff;
   assign rsp_outcome    = rsp_outcome_ff;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Bounded probe source table testbench
// Drives source lookups through the start/busy command port and checks every
// result strobe against a local copy of the slot table. Directed tests cover
// the empty table, key extremes, a full probe window that wraps past the top
// slot, oldest-entry eviction with ties, and the zero key. A random phase
// then mixes crowded hash regions, fresh keys and the zero key.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int TABLE_SLOTS = 1024;
   localparam int PROBE_DEPTH = 16;
   localparam int RUN_LIMIT   = 1_000_000;

   // One expected lookup result.
   typedef struct {
      bps_pkg::slot_index_type slot;
      bps_pkg::outcome_type    outcome;
   } lookup_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [bps_pkg::KEY_W-1:0]  req_source_ip = '0;
   logic [bps_pkg::TIME_W-1:0] req_now_time = '0;
   logic                       rsp_strobe;
   logic [9:0]                 rsp_slot_index;
   logic [1:0]                 rsp_outcome;

   // Local copy of the slot table and the results still owed by the block.
   logic [bps_pkg::KEY_W-1:0]  owner_copy [TABLE_SLOTS];
   logic [bps_pkg::TIME_W-1:0] birth_copy [TABLE_SLOTS];
   lookup_result_type          pending_lookups [$];
   lookup_result_type          head_lookup;
   int                         failures = 0;

   bounded_probe_source_table #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .PROBE_DEPTH(PROBE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_source_ip(req_source_ip),
      .req_now_time(req_now_time),
      .rsp_strobe(rsp_strobe),
      .rsp_slot_index(rsp_slot_index),
      .rsp_outcome(rsp_outcome)
   );

   // Clock with a period of 4.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Xor-shift and multiply mix of a source address.
   function automatic logic [bps_pkg::KEY_W-1:0] mix_source(
      input logic [bps_pkg::KEY_W-1:0] a);
      a = a ^ (a >> bps_pkg::MIX_SHIFT);
      a = a * bps_pkg::MIX_MULT;
      a = a ^ (a >> bps_pkg::MIX_SHIFT);
      a = a * bps_pkg::MIX_MULT;
      a = a ^ (a >> bps_pkg::MIX_SHIFT);
      return a;
   endfunction

   function automatic int home_slot(input logic [bps_pkg::KEY_W-1:0] key);
      return int'(mix_source(key) % TABLE_SLOTS);
   endfunction

   // Finds a nonzero key whose home slot lies within span slots from lo.
   function automatic logic [bps_pkg::KEY_W-1:0] key_for_window(input int lo, input int span);
      logic [bps_pkg::KEY_W-1:0] key;
      int                        offset;
      do begin
         key    = $urandom;
         offset = (home_slot(key) - lo + TABLE_SLOTS) % TABLE_SLOTS;
      end while (key == '0 || offset >= span);
      return key;
   endfunction

   // Walks the probe window of the local table, updates it and queues the
   // result the block owes for this lookup.
   function automatic void predict_lookup(input logic [bps_pkg::KEY_W-1:0]  key,
                                          input logic [bps_pkg::TIME_W-1:0] stamp);
      logic [bps_pkg::KEY_W-1:0] base;
      logic [bps_pkg::KEY_W-1:0] pos;
      int                        slot;
      int                        victim;
      bit                        have_victim;
      lookup_result_type         result;
      base        = mix_source(key);
      victim      = 0;
      have_victim = 1'b0;
      for (int i = 0; i < PROBE_DEPTH; i++) begin
         pos  = base + i;
         slot = int'(pos % TABLE_SLOTS);
         if (owner_copy[slot] == key) begin
            result.slot    = bps_pkg::slot_index_type'(slot);
            result.outcome = bps_pkg::OUTCOME_HIT;
            pending_lookups.push_back(result);
            return;
         end
         if (owner_copy[slot] == '0) begin
            owner_copy[slot] = key;
            birth_copy[slot] = stamp;
            result.slot    = bps_pkg::slot_index_type'(slot);
            result.outcome = bps_pkg::OUTCOME_CLAIM;
            pending_lookups.push_back(result);
            return;
         end
         // Strictly older only, so the first probed slot wins a tie.
         if (!have_victim || birth_copy[slot] < birth_copy[victim]) begin
            victim      = slot;
            have_victim = 1'b1;
         end
      end
      owner_copy[victim] = key;
      birth_copy[victim] = stamp;
      result.slot    = bps_pkg::slot_index_type'(victim);
      result.outcome = bps_pkg::OUTCOME_EVICT;
      pending_lookups.push_back(result);
   endfunction

   task automatic note_failure(input string msg);
      if (failures < 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      failures++;
   endtask

   // Checks each result strobe against the oldest pending expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_lookups.size() == 0) begin
            note_failure($sformatf("unexpected result slot %0d outcome %0d",
                                   rsp_slot_index, rsp_outcome));
         end else begin
            head_lookup = pending_lookups.pop_front();
            if (rsp_slot_index !== head_lookup.slot ||
                rsp_outcome !== head_lookup.outcome) begin
               note_failure($sformatf("slot exp %0d got %0d, outcome exp %s got %0d",
                                      head_lookup.slot, rsp_slot_index,
                                      head_lookup.outcome.name(), rsp_outcome));
            end
         end
      end
   end

   // Presents one lookup and holds it until the transfer takes place.
   task automatic send_lookup(input logic [bps_pkg::KEY_W-1:0]  key,
                              input logic [bps_pkg::TIME_W-1:0] stamp);
      req_source_ip <= key;
      req_now_time  <= stamp;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_lookup(key, stamp);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(5, 40);
   endfunction

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // Reset, then wait out the clearing pass of the owner store.
   task automatic test_reset_clear();
      foreach (owner_copy[i]) begin
         owner_copy[i] = '0;
         birth_copy[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Zero key on an empty table, and the all-ones key claimed then hit.
   task automatic test_empty_table();
      send_lookup(32'h0000_0000, 64'd10);
      pause_sender(pick_gap());
      send_lookup(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_lookup(32'hFFFF_FFFF, 64'd0);
      wait_for_drain();
   endtask

   // Fill a window that wraps past the top slot, hit one of its keys, evict with
   // ties, send the zero key twice (a hit on an empty slot) and evict once more.
   task automatic test_window_evict();
      logic [bps_pkg::KEY_W-1:0]  crowd [PROBE_DEPTH];
      logic [bps_pkg::TIME_W-1:0] stamp;
      foreach (crowd[j]) crowd[j] = key_for_window(1020, 1);
      foreach (crowd[j]) begin
         if (j == 0) stamp = 64'hFFFF_FFFF_FFFF_FFFF;
         else if (j == 5 || j == 9) stamp = 64'd0;
         else stamp = 64'd1000 + j;
         send_lookup(crowd[j], stamp);
         pause_sender(pick_gap());
      end
      send_lookup(crowd[3], 64'd1500);
      send_lookup(key_for_window(1020, 1), 64'd2000);
      send_lookup(key_for_window(1020, 1), 64'd2001);
      pause_sender(pick_gap());
      send_lookup(32'h0000_0000, 64'd3000);
      send_lookup(32'h0000_0000, 64'd3001);
      send_lookup(key_for_window(1020, 1), 64'd3002);
      wait_for_drain();
   endtask

   // Random traffic: crowded hash regions force hits and evictions, fresh
   // keys claim slots, and the zero key shows up now and then.
   task automatic test_random_traffic();
      logic [bps_pkg::KEY_W-1:0]  crowd [96];
      logic [bps_pkg::KEY_W-1:0]  key;
      logic [bps_pkg::KEY_W-1:0]  last_fresh;
      logic [bps_pkg::TIME_W-1:0] stamp;
      logic [bps_pkg::TIME_W-1:0] clock_us;
      int                         region_base;
      int                         roll;
      for (int r = 0; r < 3; r++) begin
         region_base = (r == 0) ? 1022 : $urandom_range(0, TABLE_SLOTS - 1);
         for (int k = 0; k < 32; k++) crowd[r * 32 + k] = key_for_window(region_base, 4);
      end
      last_fresh = 32'hFFFF_FFFF;
      clock_us   = 64'd5000;
      for (int n = 0; n < 1000; n++) begin
         // Let the table settle once midway before the next transfer.
         if (n == 500) wait_for_drain();
         roll = $urandom_range(0, 99);
         if (roll < 50) key = crowd[$urandom_range(0, 95)];
         else if (roll < 85) begin
            key        = $urandom;
            last_fresh = key;
         end
         else if (roll < 90) key = 32'h0000_0000;
         else key = last_fresh;
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            clock_us += $urandom_range(0, 3);
            stamp = clock_us;
         end
         else if (roll < 97) stamp = {$urandom, $urandom};
         else if (roll < 98) stamp = 64'd0;
         else stamp = 64'hFFFF_FFFF_FFFF_FFFF;
         send_lookup(key, stamp);
         // Back-to-back bursts at the start of every two hundred items.
         if (n % 200 >= 50) pause_sender(pick_gap());
      end
   endtask

   initial begin
      test_reset_clear();
      test_empty_table();
      test_window_evict();
      test_random_traffic();
      wait_for_drain();
      repeat (25) @(posedge clock);
      if (failures == 0 && pending_lookups.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hdl/bps_pkg.sv
hdl/bps_slot_store.sv
hdl/bounded_probe_source_table.sv
test/testbench.sv
